/* design/s3c_pkg.sv */
package s3c_pkg;

    // Pixel and register field widths.
    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int ROW_W      = 12;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Frame size limits: a minimum for both sides, and the maximum height.
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;

    // Reset values of the frame size registers.
    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(480);

    // Register select, taken from the word address bit.
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // Kernel sum range is -1020..1275, which fits a 12-bit two's complement word.
    localparam int SUM_W = 12;
    localparam int NEG_W = 10;
    localparam logic [SUM_W-1:0] PIX_MAX = SUM_W'(255);

endpackage

/* design/s3c_ram.sv */
module s3c_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/sharpen_3x3_convolution_unit.sv */
// A pixel that completes an interior window passes through stage one (line store read),
// then the output register (kernel sum), and appears on m_tvalid from that register.
// Throughput: one pixel per clock while m_tready keeps the output moving; the line stores take
// one read and one write per cycle, and a waiting result stalls the input once stage one fills.
// Reset (aresetn low, synchronous) clears the counters, the pipeline valids and the window,
// and restores a 640 x 480 frame. The line stores are not cleared.
module sharpen_3x3_convolution_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [s3c_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel_in

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [s3c_pkg::PIX_W-1:0]         m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast,   // frame_last

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [s3c_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [s3c_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [s3c_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    import s3c_pkg::*;

    // Column counter indexes the line stores directly. The comparison word is wide
    // enough for both the width register and MAX_WIDTH itself.
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WCMP_W = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

    // ------------------------------------------------------------------
    // Configuration registers. Only the word address bit selects the
    // register; byte offsets inside a word are ignored.
    // ------------------------------------------------------------------
    logic [IMG_W_W-1:0] width_reg,  width_next;
    logic [IMG_H_W-1:0] height_reg, height_next;
    logic               cfg_wr;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1];

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_IDX_WIDTH:  width_next  = pwdata[IMG_W_W-1:0];
                REG_IDX_HEIGHT: height_next = pwdata[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IDX_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IDX_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // ------------------------------------------------------------------
    // Effective frame size. Out-of-range sizes are clamped, and a counter
    // that stands at or past the last column or row wraps as if it were on it.
    // ------------------------------------------------------------------
    logic [WCMP_W-1:0]  width_ext, width_eff;
    logic [IMG_H_W-1:0] height_eff;
    logic [CW-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               last_col, last_row;
    logic               in_emit;
    logic               accept;

    assign width_ext = WCMP_W'(width_reg);

    always_comb begin
        if (width_ext < WCMP_W'(MIN_DIM)) begin
            width_eff = WCMP_W'(MIN_DIM);
        end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
            width_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end

        if (height_reg < IMG_H_W'(MIN_DIM)) begin
            height_eff = IMG_H_W'(MIN_DIM);
        end else if (height_reg > IMG_H_W'(MAX_HEIGHT)) begin
            height_eff = IMG_H_W'(MAX_HEIGHT);
        end else begin
            height_eff = height_reg;
        end
    end

    assign last_col = WCMP_W'(col_reg) >= (width_eff - WCMP_W'(1));
    assign last_row = IMG_H_W'(row_reg) >= (height_eff - IMG_H_W'(1));
    assign in_emit  = (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage one holds the accepted beat while the line stores return the
    // two pixels above it. It drains into the output register, or simply
    // retires when the beat has no interior position.
    // ------------------------------------------------------------------
    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_advance;
    logic             m_valid_reg, m_valid_next;

    assign s1_advance = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_tdata;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= in_emit;
            s1_last_reg <= last_col && last_row;
        end
    end

    // Line stores: read at accept, written back when stage one retires. The
    // same column is read again only a full row later, after that write.
    logic [PIX_W-1:0] up_rd, mid_rd;

    s3c_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_row_upper (
        .clk   (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_rd)
    );

    s3c_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_row_middle (
        .clk   (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // ------------------------------------------------------------------
    // Window. Only the taps the kernel needs after the next shift are kept:
    // top right, middle center, middle right and bottom right.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_tr_reg, win_mc_reg, win_mr_reg, win_br_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_tr_reg <= '0;
            win_mc_reg <= '0;
            win_mr_reg <= '0;
            win_br_reg <= '0;
        end else if (s1_advance) begin
            win_tr_reg <= up_rd;
            win_mc_reg <= win_mr_reg;
            win_mr_reg <= mid_rd;
            win_br_reg <= s1_pix_reg;
        end
    end

    // After the shift, the center is the old middle right pixel, and its four
    // neighbors are the old top right, old middle center, new middle right and
    // old bottom right. The sum is formed modulo 2^12 and its sign bit decides.
    logic [SUM_W-1:0] pos_sum, diff;
    logic [NEG_W-1:0] neg_sum;
    logic [PIX_W-1:0] sat_pix;

    assign pos_sum = (SUM_W'(win_mr_reg) << 2) + SUM_W'(win_mr_reg);
    assign neg_sum = NEG_W'(win_tr_reg) + NEG_W'(win_mc_reg)
                   + NEG_W'(mid_rd) + NEG_W'(win_br_reg);
    assign diff    = pos_sum - SUM_W'(neg_sum);

    always_comb begin
        if (diff[SUM_W-1]) begin
            sat_pix = '0;
        end else if (diff > PIX_MAX) begin
            sat_pix = PIX_MAX[PIX_W-1:0];
        end else begin
            sat_pix = diff[PIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] m_pix_reg;
    logic             m_last_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_advance && s1_emit_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_emit_reg) begin
            m_pix_reg  <= sat_pix;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // The input side stalls only when stage one holds a result that cannot
    // move because the output register is full.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s1_emit_reg && m_valid_reg))
        else $error("input stalled without a blocked result");

    // A retiring interior beat must land in the output register with its marker.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_emit_reg) |=> (m_valid_reg && (m_last_reg == $past(s1_last_reg))))
        else $error("result lost between stage one and the output register");

    // The last pixel of a frame returns both counters to the frame origin.
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap at end of frame");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the 3x3 sharpen filter.
// Pixels go in as beats on the s_ side, one per handshake. The bench keeps
// its own copy of the two line stores, the 3x3 window and the row and column
// counters. Every accepted pixel therefore yields either nothing or exactly one
// expected output pixel. A checker process pops these expectations in order
// as beats leave on the m_ side. Frame sizes are only changed over APB while
// nothing is in flight, and each write is read back.
module tb;

    import s3c_pkg::*;

    localparam int MAX_W                 = 2048;
    localparam int HOLD_LEN              = 300;     // long output hold-off, in cycles
    localparam int DRAIN_PAD             = 8;       // margin after the last expected beat; pad generously
    localparam int DRAIN_LIMIT           = 20000;
    localparam int CYCLE_LIMIT           = 300000;
    localparam int RANDOM_PIXELS_PER_PHASE = 280;

    // One expected output beat: the sharpened pixel and the end-of-frame flag.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } sharp_px_t;

    // ------------------------------------------------------------------
    // DUT connections. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata  = '0;       // [7:0] pixel_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIX_W-1:0]      m_tdata;             // [7:0] pixel_out
    logic                  m_tlast;             // frame_last
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sharpen_3x3_convolution_unit #(
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------
    sharp_px_t sharpened_q[$];      // expected output beats, oldest first
    int        mismatches     = 0;
    int        pixels_sent    = 0;
    int        results_seen   = 0;
    int        frames_done    = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;  // only touched by the stimulus process
    int        recv_stall_pct = 0;  // read by the receiver process, so written with <=
    int        hold_requests  = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;

    // Shadow of the filter: line stores, window and raster position.
    logic [PIX_W-1:0]   upper_line  [0:MAX_W-1];
    logic [PIX_W-1:0]   middle_line [0:MAX_W-1];
    logic [PIX_W-1:0]   win [0:2][0:2];   // [row][col], column 2 is the newest
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;
    logic [IMG_W_W-1:0] width_cfg  = WIDTH_RESET;
    logic [IMG_H_W-1:0] height_cfg = HEIGHT_RESET;

    initial begin
        for (int i = 0; i < MAX_W; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win[r][c] = '0;
            end
        end
    end

    // 100 MHz clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // A hung handshake ends the run here instead of hanging the simulator.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run exceeded %0d cycles with %0d beats still owed.",
                     CYCLE_LIMIT, sharpened_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h (output beat %0d, cycle %0d)",
                 what, want, got, results_seen, cycle_count);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Shadow filter. Called once for each accepted input pixel.
    // ------------------------------------------------------------------
    task automatic sharpen_predict(input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        bit               last_col;
        bit               last_row;
        int               sum;
        sharp_px_t        res;

        // Out-of-range sizes are clamped, not rejected.
        w = width_cfg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_W) w = MAX_W;
        h = height_cfg;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;

        // A counter that ended up past a shrunken size acts as if it sat on the last one.
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);

        up  = upper_line[col_pos];
        mid = middle_line[col_pos];
        upper_line[col_pos]  = mid;
        middle_line[col_pos] = pix;

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;

        if (row_pos >= 2 && col_pos >= 2) begin
            sum = 5 * int'(win[1][1]) - int'(win[0][1]) - int'(win[1][0])
                - int'(win[1][2]) - int'(win[2][1]);
            if (sum < 0) sum = 0;
            if (sum > 255) sum = 255;
            res.pixel     = PIX_W'(sum);
            res.frame_end = last_col && last_row;
            sharpened_q.push_back(res);
            if (res.frame_end) frames_done++;
        end

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side. The receiver randomly deasserts m_tready. It can also be
    // told to hold off, which it counts down on its own from HOLD_LEN.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every output beat is checked against the oldest expectation. Values are
    // sampled before the edge updates them, so there is no race with the DUT.
    always @(posedge aclk) begin
        sharp_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sharpened_q.size() == 0) begin
                report_mismatch("output beat with nothing expected", '0,
                                32'({m_tlast, m_tdata}));
            end else begin
                want = sharpened_q.pop_front();
                if (m_tdata !== want.pixel)
                    report_mismatch("pixel_out", 32'(want.pixel), 32'(m_tdata));
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_last", 32'(want.frame_end), 32'(m_tlast));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // One APB transfer: setup, access, then an idle step with psel low, so that a following
    // transfer never drives psel twice in the same time step.
    task automatic apb_transfer(input bit is_write, input logic idx,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes one frame-size register, updates the shadow copy and checks the readback.
    task automatic set_frame_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        logic [APB_DATA_W-1:0] stored;
        if (idx == REG_IDX_WIDTH)
            stored = value & ((32'd1 << IMG_W_W) - 1);
        else
            stored = value & ((32'd1 << IMG_H_W) - 1);
        apb_transfer(1'b1, idx, value, readback);
        if (idx == REG_IDX_WIDTH)
            width_cfg = stored[IMG_W_W-1:0];
        else
            height_cfg = stored[IMG_H_W-1:0];
        apb_transfer(1'b0, idx, '0, readback);
        if (readback !== stored)
            report_mismatch(idx == REG_IDX_WIDTH ? "image_width readback"
                                                 : "image_height readback",
                            stored, readback);
    endtask

    // Offers one pixel, after a random idle gap, and returns at the edge
    // where it is accepted.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sharpen_predict(pix);
        pixels_sent++;
    endtask

    // Drops s_tvalid and waits until every expected beat has arrived or DRAIN_LIMIT
    // runs out. Then it pads the wait by DRAIN_PAD so that nothing is left inside the pipe.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sharpened_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    // Sends w x h pixels. Content style is chosen per frame: uniform noise,
    // hard black/white, a near-flat field within 8 of a random base, or
    // isolated bright specks on a dark field.
    task automatic send_frame(input int w, input int h);
        int style;
        int base;
        int v;
        style = $urandom_range(3);
        base  = $urandom_range(255);
        for (int i = 0; i < w * h; i++) begin
            case (style)
                0: begin
                    v = $urandom_range(255);
                end
                1: begin
                    v = $urandom_range(1) ? 255 : 0;
                end
                2: begin
                    v = base + $urandom_range(16) - 8;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                default: begin
                    v = ($urandom_range(7) == 0) ? 255 - $urandom_range(15) : base / 4;
                end
            endcase
            send_pixel(PIX_W'(v));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Zero in both registers must act as the 3 x 3 minimum, so each frame
    // below gives exactly one output beat, which is also the frame end.
    // The three frames drive the sum to its upper bound, to its lower bound,
    // and to an in-range value with bright corners that the kernel must ignore.
    task automatic test_directed_extremes();
        logic [PIX_W-1:0] seq [0:26] = '{
            8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
            8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
            8'd255, 8'd20,  8'd255, 8'd40,  8'd60,  8'd50,  8'd255, 8'd80,  8'd255
        };
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        set_frame_reg(REG_IDX_WIDTH, 32'd0);
        set_frame_reg(REG_IDX_HEIGHT, 32'd0);
        for (int i = 0; i < 27; i++) send_pixel(seq[i]);
        drain_results();
    endtask

    // An all-ones width clamps to the full line store, so a 40-pixel row must
    // not wrap, and a height of 2 acts as 3. The width then drops to 6 while
    // the column counter stands far past the new last column; the next pixel
    // ends the row and two short rows finish the frame.
    task automatic test_wide_register();
        send_idle_pct = 15;
        recv_stall_pct <= 15;
        set_frame_reg(REG_IDX_WIDTH, 32'hFFF);
        set_frame_reg(REG_IDX_HEIGHT, 32'd2);
        for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom_range(255)));
        drain_results();
        set_frame_reg(REG_IDX_WIDTH, 32'd6);
        for (int i = 0; i < 13; i++) send_pixel(PIX_W'($urandom_range(255)));
        drain_results();
    endtask

    // Size registers are changed while a frame is open. The column counter
    // ends up past the new last column, then the row counter ends up past
    // the new last row. Both must wrap as if they stood on the last position.
    task automatic test_resize_mid_frame();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        set_frame_reg(REG_IDX_WIDTH, 32'd8);
        set_frame_reg(REG_IDX_HEIGHT, 32'd4);
        for (int i = 0; i < 22; i++) send_pixel(PIX_W'($urandom_range(255)));
        drain_results();
        set_frame_reg(REG_IDX_WIDTH, 32'd4);
        for (int i = 0; i < 5; i++) send_pixel(PIX_W'($urandom_range(255)));
        drain_results();

        // An all-ones height clamps to the maximum; four rows in, the height drops to 3.
        set_frame_reg(REG_IDX_WIDTH, 32'd5);
        set_frame_reg(REG_IDX_HEIGHT, 32'h1FFF);
        for (int i = 0; i < 20; i++) send_pixel(PIX_W'($urandom_range(255)));
        drain_results();
        set_frame_reg(REG_IDX_HEIGHT, 32'd3);
        for (int i = 0; i < 5; i++) send_pixel(PIX_W'($urandom_range(255)));
        drain_results();
    endtask

    // The receiver is told to hold off, counting down from HOLD_LEN, while pixels keep coming with no
    // gaps. The filter has to fill up and push back on s_tready without
    // losing or repeating a beat.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        set_frame_reg(REG_IDX_WIDTH, 32'd10);
        set_frame_reg(REG_IDX_HEIGHT, 32'd10);
        hold_requests <= hold_requests + 1;
        send_frame(10, 10);
        drain_results();
    endtask

    // Random frames, mostly small ones, under four idling patterns: none,
    // a bursty sender, a stalling receiver, and both at once. Narrow frames
    // sometimes use register values below the minimum.
    task automatic test_random_frames();
        int send_pct [0:3] = '{0, 58, 0, 15};
        int recv_pct [0:3] = '{0, 0, 58, 15};
        int start;
        int w;
        int h;
        int w_reg;
        int h_reg;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pct[p];
            recv_stall_pct <= recv_pct[p];
            start = pixels_sent;
            while (pixels_sent - start < RANDOM_PIXELS_PER_PHASE) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
                h = $urandom_range(3, 6);
                w_reg = (w == 3 && $urandom_range(1)) ? $urandom_range(2) : w;
                h_reg = (h == 3 && $urandom_range(1)) ? $urandom_range(2) : h;
                set_frame_reg(REG_IDX_WIDTH, w_reg);
                set_frame_reg(REG_IDX_HEIGHT, h_reg);
                send_frame(w, h);
                drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: a single reset, then each test in turn, then the verdict.
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed_extremes();
        test_wide_register();
        test_resize_mid_frame();
        test_output_backpressure();
        test_random_frames();

        drain_results();
        if (sharpened_q.size() != 0)
            report_mismatch("output beats never delivered", 0, sharpened_q.size());

        $display("Sent %0d pixels over %0d frames and checked %0d sharpened beats.",
                 pixels_sent, frames_done, results_seen);
        $display("Covered size clamps, resizes and a %0d-cycle hold-off; %0d mismatches.",
                 HOLD_LEN, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
design/s3c_pkg.sv
design/s3c_ram.sv
design/sharpen_3x3_convolution_unit.sv
bench/tb.sv
